/* design/cau_pkg.sv */
// Package for the complex arithmetic unit: opcodes, status codes, stage type,
// saturation helpers. No dependencies.
package cau_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int DIV_STEPS = 33;

    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_SUB  = 3'd1;
    localparam logic [2:0] OP_MUL  = 3'd2;
    localparam logic [2:0] OP_DIV  = 3'd3;
    localparam logic [2:0] OP_NORM = 3'd4;
    localparam logic [2:0] OP_MAG  = 3'd5;
    localparam logic [2:0] OP_GT   = 3'd6;
    localparam logic [2:0] OP_EQ   = 3'd7;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_SAT = 2'd1;
    localparam logic [1:0] ST_DZ  = 2'd2;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] re;
        logic [31:0] im;
        logic        flag;
        logic [1:0]  status;
        logic        nbz;
        logic        neg_re;
        logic        neg_im;
        logic        ov_re;
        logic        ov_im;
        logic [63:0] den;
        logic [96:0] rem_re;
        logic [96:0] rem_im;
        logic [32:0] q_re;
        logic [32:0] q_im;
        logic [65:0] srem;
        logic [31:0] root;
    } stage_t;

    // {sat, value}: clamp a signed wide value to the 32-bit word
    function automatic logic [32:0] sat_s(logic signed [64:0] v);
        logic [32:0] r;
        r = {1'b0, v[31:0]};
        if (v > 65'sh0_7FFF_FFFF)
            r = {1'b1, 32'h7FFF_FFFF};
        else if (v < -65'sh0_8000_0000)
            r = {1'b1, 32'h8000_0000};
        return r;
    endfunction

    // {sat, value}: clamp a sign and magnitude to the 32-bit word
    function automatic logic [32:0] sat_m(logic neg, logic [63:0] mag);
        logic [63:0] m;
        logic        s;
        logic [63:0] o;
        m = mag;
        s = 1'b0;
        if (!neg && mag > 64'h7FFF_FFFF)
        begin
            m = 64'h7FFF_FFFF;
            s = 1'b1;
        end
        if (neg && mag > 64'h8000_0000)
        begin
            m = 64'h8000_0000;
            s = 1'b1;
        end
        o = neg ? (64'd0 - m) : m;
        return {s, o[31:0]};
    endfunction

endpackage

/* design/complex_arith_unit.sv */
// Complex arithmetic unit top level: add, subtract, multiply, divide, squared norm,
// square-root magnitude and compare pipeline. Depends on cau_pkg.
//
//  channel  | dir | payload
//  s_*      | in  | tuser: op ; tdata: a_re, a_im, b_re, b_im
//  m_*      | out | tuser: flag, status ; tdata: res_re, res_im
//
// One request per cycle while the output is not stalled; the pipeline length is set
// by the 33 divider steps, which also carry the 32 square-root steps.
// rst_n clears all valid bits. A stall at the output holds every stage.
module complex_arith_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // a_re, a_im, b_re, b_im
    input  logic [2:0]   s_tuser,   // op
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // res_re, res_im
    output logic [2:0]   m_tuser    // flag, status
);

    localparam int DIV_LEN = cau_pkg::DIV_STEPS;

    logic adv;

    logic        v1_reg;
    logic [2:0]  op1_reg;
    logic signed [31:0] ar1_reg, ai1_reg, br1_reg, bi1_reg;
    logic signed [63:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [63:0] p_aa_reg, p_ab_reg, p_ba_reg, p_bb_reg;

    logic        v2_reg;
    logic [2:0]  op2_reg;
    logic signed [31:0] ar2_reg, ai2_reg, br2_reg, bi2_reg;
    logic signed [64:0] mre_reg, mim_reg, dre_reg, dim_reg;
    logic [63:0] na_reg, nb_reg;

    logic [DIV_LEN:0] vs_reg;
    cau_pkg::stage_t st_reg [0:DIV_LEN];
    cau_pkg::stage_t st0_next;

    logic        vo_reg;
    logic [31:0] ore_reg, oim_reg;
    logic        oflag_reg;
    logic [1:0]  ost_reg;
    logic [31:0] ore_next, oim_next;
    logic        oflag_next;
    logic [1:0]  ost_next;

    assign adv      = !vo_reg || m_tready;
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vs_reg <= '0;
            vo_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            vs_reg <= {vs_reg[DIV_LEN-1:0], v2_reg};
            vo_reg <= vs_reg[DIV_LEN];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op1_reg  <= s_tuser;
            ar1_reg  <= s_tdata[31:0];
            ai1_reg  <= s_tdata[63:32];
            br1_reg  <= s_tdata[95:64];
            bi1_reg  <= s_tdata[127:96];
            p_rr_reg <= $signed(s_tdata[31:0])   * $signed(s_tdata[95:64]);
            p_ii_reg <= $signed(s_tdata[63:32])  * $signed(s_tdata[127:96]);
            p_ri_reg <= $signed(s_tdata[31:0])   * $signed(s_tdata[127:96]);
            p_ir_reg <= $signed(s_tdata[63:32])  * $signed(s_tdata[95:64]);
            p_aa_reg <= $signed(s_tdata[31:0])   * $signed(s_tdata[31:0]);
            p_ab_reg <= $signed(s_tdata[63:32])  * $signed(s_tdata[63:32]);
            p_ba_reg <= $signed(s_tdata[95:64])  * $signed(s_tdata[95:64]);
            p_bb_reg <= $signed(s_tdata[127:96]) * $signed(s_tdata[127:96]);

            op2_reg <= op1_reg;
            ar2_reg <= ar1_reg;
            ai2_reg <= ai1_reg;
            br2_reg <= br1_reg;
            bi2_reg <= bi1_reg;
            mre_reg <= 65'(p_rr_reg) - 65'(p_ii_reg);
            mim_reg <= 65'(p_ri_reg) + 65'(p_ir_reg);
            dre_reg <= 65'(p_rr_reg) + 65'(p_ii_reg);
            dim_reg <= 65'(p_ir_reg) - 65'(p_ri_reg);
            na_reg  <= 64'(p_aa_reg) + 64'(p_ab_reg);
            nb_reg  <= 64'(p_ba_reg) + 64'(p_bb_reg);

            st_reg[0] <= st0_next;
        end
    end

    always_comb
    begin
        logic [32:0] sr;
        logic [32:0] si;
        logic [63:0] axr;
        logic [63:0] axi;
        logic [47:0] nsh;
        sr  = '0;
        si  = '0;
        nsh = na_reg[63:cau_pkg::FRAC_BITS];
        axr = dre_reg[64] ? 64'(-dre_reg) : dre_reg[63:0];
        axi = dim_reg[64] ? 64'(-dim_reg) : dim_reg[63:0];
        st0_next        = '0;
        st0_next.op     = op2_reg;
        st0_next.den    = nb_reg;
        st0_next.nbz    = (nb_reg == 64'd0);
        st0_next.neg_re = dre_reg[64];
        st0_next.neg_im = dim_reg[64];
        st0_next.rem_re = {17'd0, axr, 16'd0};
        st0_next.rem_im = {17'd0, axi, 16'd0};
        st0_next.ov_re  = ({17'd0, axr, 16'd0} >= {nb_reg, 33'd0});
        st0_next.ov_im  = ({17'd0, axi, 16'd0} >= {nb_reg, 33'd0});
        st0_next.srem   = {2'b00, na_reg};
        unique case (op2_reg)
            cau_pkg::OP_ADD:
            begin
                sr = cau_pkg::sat_s(65'(ar2_reg) + 65'(br2_reg));
                si = cau_pkg::sat_s(65'(ai2_reg) + 65'(bi2_reg));
            end
            cau_pkg::OP_SUB:
            begin
                sr = cau_pkg::sat_s(65'(ar2_reg) - 65'(br2_reg));
                si = cau_pkg::sat_s(65'(ai2_reg) - 65'(bi2_reg));
            end
            cau_pkg::OP_MUL:
            begin
                sr = cau_pkg::sat_s(mre_reg >>> cau_pkg::FRAC_BITS);
                si = cau_pkg::sat_s(mim_reg >>> cau_pkg::FRAC_BITS);
            end
            cau_pkg::OP_NORM:
                sr = cau_pkg::sat_m(1'b0, {16'd0, nsh});
            cau_pkg::OP_GT:
                st0_next.flag = (na_reg > nb_reg);
            cau_pkg::OP_EQ:
                st0_next.flag = (ar2_reg == br2_reg) && (ai2_reg == bi2_reg);
            default:
            begin
                sr = '0;
            end
        endcase
        st0_next.re     = sr[31:0];
        st0_next.im     = si[31:0];
        st0_next.status = (sr[32] || si[32]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
    end

    for (genvar j = 0; j < DIV_LEN; j++)
    begin : g_step
        localparam int  K  = DIV_LEN - 1 - j;
        localparam bit  SQ = (K <= 31);
        localparam int  SI = SQ ? K : 0;
        cau_pkg::stage_t nx;
        always_comb
        begin
            logic [96:0] dsh;
            logic [65:0] term;
            dsh  = {33'd0, st_reg[j].den} << K;
            term = ({34'd0, st_reg[j].root} << (SI + 1)) + (66'd1 << (2 * SI));
            nx   = st_reg[j];
            if (st_reg[j].rem_re >= dsh)
            begin
                nx.rem_re  = st_reg[j].rem_re - dsh;
                nx.q_re[K] = 1'b1;
            end
            if (st_reg[j].rem_im >= dsh)
            begin
                nx.rem_im  = st_reg[j].rem_im - dsh;
                nx.q_im[K] = 1'b1;
            end
            if (SQ && st_reg[j].srem >= term)
            begin
                nx.srem     = st_reg[j].srem - term;
                nx.root[SI] = 1'b1;
            end
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                st_reg[j+1] <= nx;
            end
        end
    end

    always_comb
    begin
        logic [32:0] fr;
        logic [32:0] fi;
        logic [32:0] fm;
        logic [63:0] mr;
        logic [63:0] mi;
        mr = st_reg[DIV_LEN].ov_re ? 64'h8000_0001 : {31'd0, st_reg[DIV_LEN].q_re};
        mi = st_reg[DIV_LEN].ov_im ? 64'h8000_0001 : {31'd0, st_reg[DIV_LEN].q_im};
        fr = cau_pkg::sat_m(st_reg[DIV_LEN].neg_re && (mr != 64'd0), mr);
        fi = cau_pkg::sat_m(st_reg[DIV_LEN].neg_im && (mi != 64'd0), mi);
        fm = cau_pkg::sat_m(1'b0, {32'd0, st_reg[DIV_LEN].root});
        ore_next   = st_reg[DIV_LEN].re;
        oim_next   = st_reg[DIV_LEN].im;
        oflag_next = st_reg[DIV_LEN].flag;
        ost_next   = st_reg[DIV_LEN].status;
        if (st_reg[DIV_LEN].op == cau_pkg::OP_DIV)
        begin
            if (st_reg[DIV_LEN].nbz)
            begin
                ore_next = '0;
                oim_next = '0;
                ost_next = cau_pkg::ST_DZ;
            end
            else
            begin
                ore_next = fr[31:0];
                oim_next = fi[31:0];
                ost_next = (fr[32] || fi[32]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
            end
        end
        else if (st_reg[DIV_LEN].op == cau_pkg::OP_MAG)
        begin
            ore_next = fm[31:0];
            oim_next = '0;
            ost_next = fm[32] ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ore_reg   <= ore_next;
            oim_reg   <= oim_next;
            oflag_reg <= oflag_next;
            ost_reg   <= ost_next;
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = {oim_reg, ore_reg};
    assign m_tuser  = {ost_reg, oflag_reg};

endmodule

/* design/cau_checker.sv */
// Port-level checker for the complex arithmetic unit and its bind.
// Depends on cau_pkg and complex_arith_unit.
module cau_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [127:0] s_tdata,
    input logic [2:0]   s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [63:0]  m_tdata,
    input logic [2:0]   m_tuser
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped under stall");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser[2:1] != 2'd3)
        else $error("bad status code");

    a_dz: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[2:1] == cau_pkg::ST_DZ |-> m_tdata == 64'd0 && !m_tuser[0])
        else $error("divide by zero result not cleared");

    a_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tuser[2:1] == cau_pkg::ST_OK && m_tdata == 64'd0)
        else $error("flag set with nonzero result");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input held while output empty");

endmodule

bind complex_arith_unit cau_checker u_cau_checker (.*);
